FILE: sv/pixel_clip_blend_write_assert.svh
// assertion macros for the pixel clip/blend/write block
// included by the rtl files that carry concurrent checks; no other dependencies
`ifndef PIXEL_CLIP_BLEND_WRITE_ASSERT_SVH
`define PIXEL_CLIP_BLEND_WRITE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled while in reset
`define PCBW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication, disabled while in reset
`define PCBW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define PCBW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PCBW_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/pcbw_pkg.sv
// shared types and constants for the pixel clip/blend/write block
// no dependencies
package pcbw_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = 13;
    localparam int COORD_W    = 14;
    localparam int CHAN_W     = 8;
    localparam int WORD_W     = 32;
    localparam int OFFSET_W   = 24;
    localparam int MODE_W     = 3;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE   = 3'd0,
        MODE_ALPHA  = 3'd1,
        MODE_ADD    = 3'd2,
        MODE_MULT   = 3'd3,
        MODE_SCREEN = 3'd4
    } rop_mode_t;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_ROW_STRIDE   = 2'd2,
        REG_ROP_MODE     = 2'd3
    } reg_index_t;

    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 13'd480;
    localparam logic [DIM_W-1:0]  RST_ROW_STRIDE   = 13'd640;
    localparam logic [MODE_W-1:0] RST_ROP_MODE     = MODE_ALPHA;
    localparam logic [CHAN_W-1:0] CHAN_MAX         = 8'hFF;

endpackage

FILE: sv/pcbw_ifs.sv
// word channels of the pixel clip/blend/write block: pixel input and write output
// depends on pcbw_pkg
interface pcbw_in_if;
    import pcbw_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [CHAN_W-1:0]         src_red;
    logic [CHAN_W-1:0]         src_green;
    logic [CHAN_W-1:0]         src_blue;
    logic [CHAN_W-1:0]         src_alpha;
    logic [WORD_W-1:0]         dest_word;

    modport source (
        output valid, pos_x, pos_y, src_red, src_green, src_blue, src_alpha, dest_word,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, src_red, src_green, src_blue, src_alpha, dest_word,
        output ready
    );
endinterface

interface pcbw_out_if;
    import pcbw_pkg::*;

    logic                valid;
    logic                ready;
    logic                write_enable;
    logic [OFFSET_W-1:0] word_offset;
    logic [WORD_W-1:0]   pixel_word;

    modport source (
        output valid, write_enable, word_offset, pixel_word,
        input  ready
    );
    modport sink (
        input  valid, write_enable, word_offset, pixel_word,
        output ready
    );
endinterface

FILE: sv/pixel_clip_blend_write.sv
// pixel clip/blend/write top level: apb register file, input word register, result register
// depends on pcbw_pkg, pcbw_ifs.sv and pixel_clip_blend_write_assert.svh
//
// usage
//   pix_in carries one pixel word: signed position, source rgba and the destination
//   framebuffer word. pix_out returns one word per input: write_enable, word_offset
//   (row * stride + column, modulo 2^24) and the packed rgba pixel_word.
//   Clipped pixels come out with write_enable, word_offset and pixel_word all zero.
//   The apb port holds frame_width, frame_height, row_stride_words and the raster op
//   mode at byte addresses 0, 4, 8 and 12; write them only while no word is in flight.
//   A word taken at pix_in sits in the input register; the clip, offset multiply and
//   per-channel blend are combinational and land in the result register, which
//   drives pix_out. Throughput is one word per cycle while pix_out is ready, set by
//   the two-entry register pipeline. When pix_out stalls, the input register still
//   takes one more word, then pix_in.ready drops until the result register drains.
//   Reset empties both stages and loads 640 x 480, stride 640, alpha blending.
`include "pixel_clip_blend_write_assert.svh"

module pixel_clip_blend_write (
    input  logic                              clk,
    input  logic                              rst_n,
    pcbw_in_if.sink                           pix_in,
    pcbw_out_if.source                        pix_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pcbw_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pcbw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pcbw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import pcbw_pkg::*;

    localparam int PROD_W = 2 * CHAN_W;
    localparam int SUM_W  = PROD_W + 1;

    // configuration registers
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [DIM_W-1:0]  stride_reg;
    logic [MODE_W-1:0] mode_reg;
    logic              cfg_write;
    reg_index_t        cfg_index;

    // input stage
    logic                      s1_valid_reg;
    logic signed [COORD_W-1:0] s1_x_reg;
    logic signed [COORD_W-1:0] s1_y_reg;
    logic [CHAN_W-1:0]         s1_src_reg [3];
    logic [CHAN_W-1:0]         s1_alpha_reg;
    logic [WORD_W-1:0]         s1_dest_reg;

    // result stage
    logic                out_valid_reg;
    logic                out_we_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [WORD_W-1:0]   out_pixel_reg;

    logic                out_advance;
    logic                in_take;

    logic [DIM_W-1:0]     lim_width;
    logic [DIM_W-1:0]     lim_height;
    logic [DIM_W-1:0]     lim_stride;
    logic                 in_frame;
    logic [2*DIM_W-1:0]   row_base;
    logic [OFFSET_W-1:0]  offset_next;
    logic [WORD_W-1:0]    pixel_next;
    logic [CHAN_W-1:0]    dest_ch [3];
    logic [CHAN_W-1:0]    alpha_ch [3];
    logic [CHAN_W-1:0]    add_ch [3];
    logic [CHAN_W-1:0]    mult_ch [3];
    logic [SUM_W-1:0]     alpha_sum [3];
    logic [SUM_W-1:0]     add_sum [3];
    logic [CHAN_W-1:0]    alpha_comp;

    // exact floor(v / 255) for v below 65280
    function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] t;
        t = v + {{(SUM_W-1){1'b0}}, 1'b1} + (v >> CHAN_W);
        return t[CHAN_W +: CHAN_W];
    endfunction

    function automatic logic [DIM_W-1:0] lim_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
    endfunction

    // apb register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_FRAME_WIDTH;
            height_reg <= RST_FRAME_HEIGHT;
            stride_reg <= RST_ROW_STRIDE;
            mode_reg   <= RST_ROP_MODE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_ROW_STRIDE:   stride_reg <= pwdata[DIM_W-1:0];
                REG_ROP_MODE:     mode_reg   <= pwdata[MODE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_reg);
            REG_ROW_STRIDE:   prdata = APB_DATA_W'(stride_reg);
            REG_ROP_MODE:     prdata = APB_DATA_W'(mode_reg);
            default:          prdata = '0;
        endcase
    end

    // pipeline flow control
    assign out_advance  = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = !s1_valid_reg || out_advance;
    assign in_take      = pix_in.valid && pix_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pix_in.ready)
            begin
                s1_valid_reg <= pix_in.valid;
            end
            if (out_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_x_reg      <= pix_in.pos_x;
            s1_y_reg      <= pix_in.pos_y;
            s1_src_reg[0] <= pix_in.src_red;
            s1_src_reg[1] <= pix_in.src_green;
            s1_src_reg[2] <= pix_in.src_blue;
            s1_alpha_reg  <= pix_in.src_alpha;
            s1_dest_reg   <= pix_in.dest_word;
        end
        if (out_advance && s1_valid_reg)
        begin
            out_we_reg     <= in_frame;
            out_offset_reg <= in_frame ? offset_next : '0;
            out_pixel_reg  <= in_frame ? pixel_next : '0;
        end
    end

    // clip and offset
    always_comb
    begin
        lim_width   = lim_dim(width_reg);
        lim_height  = lim_dim(height_reg);
        lim_stride  = lim_dim(stride_reg);
        in_frame    = !s1_x_reg[COORD_W-1] && !s1_y_reg[COORD_W-1]
                      && (s1_x_reg[DIM_W-1:0] < lim_width)
                      && (s1_y_reg[DIM_W-1:0] < lim_height);
        row_base    = s1_y_reg[DIM_W-1:0] * lim_stride;
        offset_next = row_base[OFFSET_W-1:0] + OFFSET_W'(s1_x_reg[DIM_W-1:0]);
    end

    // per-channel blend
    always_comb
    begin
        alpha_comp = CHAN_MAX - s1_alpha_reg;
        for (int i = 0; i < 3; i++)
        begin
            dest_ch[i]   = s1_dest_reg[WORD_W-CHAN_W*(i+1) +: CHAN_W];
            alpha_sum[i] = SUM_W'(PROD_W'(s1_src_reg[i]) * PROD_W'(s1_alpha_reg))
                           + SUM_W'(PROD_W'(dest_ch[i]) * PROD_W'(alpha_comp));
            alpha_ch[i]  = div255(alpha_sum[i]);
            add_sum[i]   = SUM_W'(s1_src_reg[i]) + SUM_W'(dest_ch[i]);
            add_ch[i]    = (add_sum[i] > SUM_W'(CHAN_MAX)) ? CHAN_MAX
                                                           : add_sum[i][CHAN_W-1:0];
            mult_ch[i]   = div255(SUM_W'(PROD_W'(s1_src_reg[i]) * PROD_W'(dest_ch[i])));
        end

        pixel_next = {s1_src_reg[0], s1_src_reg[1], s1_src_reg[2], s1_alpha_reg};
        if (mode_reg != MODE_NONE && s1_alpha_reg != CHAN_MAX)
        begin
            case (rop_mode_t'(mode_reg))
                MODE_ALPHA:
                begin
                    if (s1_alpha_reg == '0)
                    begin
                        pixel_next = s1_dest_reg;
                    end
                    else
                    begin
                        pixel_next = {alpha_ch[0], alpha_ch[1], alpha_ch[2], CHAN_MAX};
                    end
                end
                MODE_ADD:  pixel_next = {add_ch[0], add_ch[1], add_ch[2], CHAN_MAX};
                MODE_MULT: pixel_next = {mult_ch[0], mult_ch[1], mult_ch[2], CHAN_MAX};
                default:   ;
            endcase
        end
    end

    assign pix_out.valid        = out_valid_reg;
    assign pix_out.write_enable = out_we_reg;
    assign pix_out.word_offset  = out_offset_reg;
    assign pix_out.pixel_word   = out_pixel_reg;

    // checks
    `PCBW_ASSERT_IMP(a_clip_zero, clk, rst_n,
        out_valid_reg && !out_we_reg, out_offset_reg == '0 && out_pixel_reg == '0)
    `PCBW_ASSERT_IMP(a_full_stall, clk, rst_n,
        s1_valid_reg && out_valid_reg && !pix_out.ready, !pix_in.ready)
    `PCBW_ASSERT_NXT(a_take_fills, clk, rst_n,
        in_take, s1_valid_reg)
    `PCBW_ASSERT_NXT(a_result_kept, clk, rst_n,
        out_valid_reg && !pix_out.ready, out_valid_reg && $stable(out_pixel_reg))

endmodule

FILE: tb/pixel_clip_blend_write_test.sv
`timescale 1ns / 100ps
// testbench for pixel_clip_blend_write: directed and random pixel words under changing idling
// predicts clip, word offset and blend per word; depends on pcbw_pkg, pcbw_ifs.sv and pixel_clip_blend_write
module pixel_clip_blend_write_test;
    import pcbw_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int BLOCKS      = 5;
    localparam int BLOCK_WORDS = 123;

    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [CHAN_W-1:0]  src_red;
        logic [CHAN_W-1:0]  src_green;
        logic [CHAN_W-1:0]  src_blue;
        logic [CHAN_W-1:0]  src_alpha;
        logic [WORD_W-1:0]  dest_word;
    } pixel_item_t;

    typedef struct packed {
        logic                write_enable;
        logic [OFFSET_W-1:0] word_offset;
        logic [WORD_W-1:0]   pixel_word;
    } write_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pcbw_in_if  pix_in ();
    pcbw_out_if pix_out ();

    logic [DIM_W-1:0]  cfg_width;
    logic [DIM_W-1:0]  cfg_height;
    logic [DIM_W-1:0]  cfg_stride;
    logic [MODE_W-1:0] cfg_mode;

    write_result_t pending_writes[$];
    int            error_count;
    int            cycle_count;
    int            src_idle_pct;
    int            sink_idle_pct;

    pixel_clip_blend_write DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("pixel_clip_blend_write_test failed");
        $finish;
    end

    function automatic write_result_t predict_write(pixel_item_t p);
        int x, y, w, h, st, a, off;
        int s[3], d[3], o[3];
        write_result_t r;
        x  = $signed(p.pos_x);
        y  = $signed(p.pos_y);
        w  = (cfg_width  > MAX_DIM) ? MAX_DIM : cfg_width;
        h  = (cfg_height > MAX_DIM) ? MAX_DIM : cfg_height;
        st = (cfg_stride > MAX_DIM) ? MAX_DIM : cfg_stride;
        a  = p.src_alpha;
        r  = '0;
        if (x < 0 || y < 0 || x >= w || y >= h)
            return r;
        s[0] = p.src_red;
        s[1] = p.src_green;
        s[2] = p.src_blue;
        for (int i = 0; i < 3; i++)
            d[i] = p.dest_word[31-8*i -: 8];
        off = y * st + x;
        r.write_enable = 1'b1;
        r.word_offset  = off[OFFSET_W-1:0];
        if (cfg_mode == MODE_NONE || a == 255)
            r.pixel_word = {p.src_red, p.src_green, p.src_blue, p.src_alpha};
        else if (cfg_mode == MODE_ALPHA && a == 0)
            r.pixel_word = p.dest_word;
        else if (cfg_mode == MODE_ALPHA || cfg_mode == MODE_ADD || cfg_mode == MODE_MULT)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (cfg_mode == MODE_ALPHA)
                    o[i] = (s[i] * a + d[i] * (255 - a)) / 255;
                else if (cfg_mode == MODE_ADD)
                    o[i] = (s[i] + d[i] > 255) ? 255 : s[i] + d[i];
                else
                    o[i] = (s[i] * d[i]) / 255;
            end
            r.pixel_word = {o[0][7:0], o[1][7:0], o[2][7:0], CHAN_MAX};
        end
        else
            r.pixel_word = {p.src_red, p.src_green, p.src_blue, p.src_alpha};
        return r;
    endfunction

    // receiver side: random stalls
    always @(negedge clk)
        pix_out.ready <= ($urandom_range(99) >= sink_idle_pct);

    always @(posedge clk)
    begin
        write_result_t exp_w;
        if (rst_n && pix_out.valid && pix_out.ready)
        begin
            if (pending_writes.size() == 0)
            begin
                $display("%0t: unexpected word: write_enable %b word_offset %h pixel_word %h",
                         $time, pix_out.write_enable, pix_out.word_offset, pix_out.pixel_word);
                error_count++;
            end
            else
            begin
                exp_w = pending_writes.pop_front();
                if (pix_out.write_enable !== exp_w.write_enable)
                begin
                    $display("%0t: write_enable expected %b actual %b",
                             $time, exp_w.write_enable, pix_out.write_enable);
                    error_count++;
                end
                if (pix_out.word_offset !== exp_w.word_offset)
                begin
                    $display("%0t: word_offset expected %h actual %h",
                             $time, exp_w.word_offset, pix_out.word_offset);
                    error_count++;
                end
                if (pix_out.pixel_word !== exp_w.pixel_word)
                begin
                    $display("%0t: pixel_word expected %h actual %h",
                             $time, exp_w.pixel_word, pix_out.pixel_word);
                    error_count++;
                end
            end
        end
    end

    task automatic send_pixel(input pixel_item_t p);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            pix_in.valid = 1'b0;
            @(negedge clk);
        end
        pix_in.pos_x     = p.pos_x;
        pix_in.pos_y     = p.pos_y;
        pix_in.src_red   = p.src_red;
        pix_in.src_green = p.src_green;
        pix_in.src_blue  = p.src_blue;
        pix_in.src_alpha = p.src_alpha;
        pix_in.dest_word = p.dest_word;
        pix_in.valid     = 1'b1;
        do
            @(posedge clk);
        while (!pix_in.ready);
        pending_writes.push_back(predict_write(p));
    endtask

    task automatic drain_writes();
        @(negedge clk);
        pix_in.valid = 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_FRAME_WIDTH:  cfg_width  = value[DIM_W-1:0];
            REG_FRAME_HEIGHT: cfg_height = value[DIM_W-1:0];
            REG_ROW_STRIDE:   cfg_stride = value[DIM_W-1:0];
            REG_ROP_MODE:     cfg_mode   = value[MODE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic pixel_item_t make_pixel(int x, int y, logic [31:0] src,
                                               logic [31:0] dest);
        pixel_item_t p;
        p.pos_x = x[COORD_W-1:0];
        p.pos_y = y[COORD_W-1:0];
        {p.src_red, p.src_green, p.src_blue, p.src_alpha} = src;
        p.dest_word = dest;
        return p;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(int lim);
        int sel, v;
        sel = $urandom_range(9);
        if (sel <= 6)
            v = int'($urandom_range(lim + 3)) - 2;
        else if (sel <= 8)
            v = $urandom;
        else
            v = $urandom_range(1) ? lim : lim - 1;
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [CHAN_W-1:0] pick_chan();
        int sel;
        sel = $urandom_range(5);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return CHAN_MAX;
        return CHAN_W'($urandom_range(255));
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int sel;
        sel = $urandom_range(11);
        case (sel)
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return 13'd4095;
            3:       return 13'd4096;
            4:       return 13'd4097;
            5:       return 13'd8191;
            default: return DIM_W'($urandom_range(2, 800));
        endcase
    endfunction

    function automatic pixel_item_t random_pixel();
        pixel_item_t p;
        int w, h;
        w = (cfg_width  > MAX_DIM) ? MAX_DIM : cfg_width;
        h = (cfg_height > MAX_DIM) ? MAX_DIM : cfg_height;
        p.pos_x     = pick_coord(w);
        p.pos_y     = pick_coord(h);
        p.src_red   = pick_chan();
        p.src_green = pick_chan();
        p.src_blue  = pick_chan();
        p.src_alpha = pick_chan();
        p.dest_word = $urandom;
        return p;
    endfunction

    task automatic test_reset_defaults();
        send_pixel(make_pixel(0, 0, 32'h80402080, 32'h10203040));
        send_pixel(make_pixel(639, 479, 32'h123456FF, 32'hFFFFFFFF));
        send_pixel(make_pixel(640, 0, 32'hFFFFFF80, 32'h00000000));
        send_pixel(make_pixel(0, 480, 32'hFFFFFF80, 32'h00000000));
        send_pixel(make_pixel(-1, 5, 32'hFFFFFF80, 32'hFFFFFFFF));
        send_pixel(make_pixel(5, -1, 32'hFFFFFF80, 32'hFFFFFFFF));
        send_pixel(make_pixel(-8192, -8192, 32'hFFFFFFFF, 32'hFFFFFFFF));
        send_pixel(make_pixel(8191, 8191, 32'hFFFFFFFF, 32'hFFFFFFFF));
        send_pixel(make_pixel(3, 2, 32'hFFFFFF00, 32'hA5C3E701));
        send_pixel(make_pixel(7, 9, 32'h00000001, 32'hFFFFFFFF));
    endtask

    task automatic test_rop_modes();
        for (int m = 0; m < 8; m++)
        begin
            drain_writes();
            write_reg(REG_ROP_MODE, m);
            send_pixel(make_pixel(10, 20, 32'hFFFFFF80, 32'hFFFFFFFF));
            send_pixel(make_pixel(11, 20, $urandom & 32'hFFFFFF00, $urandom));
        end
    endtask

    task automatic test_frame_limits();
        drain_writes();
        write_reg(REG_FRAME_WIDTH, 8191);
        write_reg(REG_FRAME_HEIGHT, 8191);
        write_reg(REG_ROW_STRIDE, 8191);
        send_pixel(make_pixel(4095, 4095, 32'h336699C0, 32'h996633FF));
        send_pixel(make_pixel(4096, 0, 32'h336699C0, 32'h996633FF));
        drain_writes();
        write_reg(REG_FRAME_WIDTH, 0);
        send_pixel(make_pixel(0, 0, 32'h336699C0, 32'h996633FF));
        drain_writes();
        write_reg(REG_FRAME_WIDTH, 4096);
        write_reg(REG_ROW_STRIDE, 0);
        send_pixel(make_pixel(100, 200, 32'h336699C0, 32'h996633FF));
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int b = 0; b < BLOCKS; b++)
        begin
            drain_writes();
            write_reg(REG_FRAME_WIDTH, pick_dim());
            write_reg(REG_FRAME_HEIGHT, pick_dim());
            write_reg(REG_ROW_STRIDE, pick_dim());
            write_reg(REG_ROP_MODE, $urandom_range(7));
            for (int i = 0; i < BLOCK_WORDS; i++)
            begin
                // let the pipeline empty once in the middle of the stream
                if (b == 1 && i == BLOCK_WORDS / 2)
                    drain_writes();
                send_pixel(random_pixel());
            end
        end
        drain_writes();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        pix_in.valid      = 1'b0;
        pix_in.pos_x      = '0;
        pix_in.pos_y      = '0;
        pix_in.src_red    = '0;
        pix_in.src_green  = '0;
        pix_in.src_blue   = '0;
        pix_in.src_alpha  = '0;
        pix_in.dest_word  = '0;
        error_count       = 0;
        src_idle_pct      = 34;
        sink_idle_pct     = 70;
        cfg_width         = RST_FRAME_WIDTH;
        cfg_height        = RST_FRAME_HEIGHT;
        cfg_stride        = RST_ROW_STRIDE;
        cfg_mode          = RST_ROP_MODE;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_rop_modes();
        test_frame_limits();
        test_random_traffic(34, 70);
        test_random_traffic(70, 34);
        test_random_traffic(0, 0);

        drain_writes();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("pixel_clip_blend_write_test passed");
        else
            $display("pixel_clip_blend_write_test failed");
        $finish;
    end

endmodule
